// ===== sv/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the servo frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    // Largest command plus data byte count that fits the packet store.
    localparam int MAX_BODY    = 13;
    // ID and length bytes come ahead of the body.
    localparam int STORE_DEPTH = MAX_BODY + 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_BODY + 1);

    localparam int BYTE_W      = 8;
    localparam int PAYLOAD_W   = 4;
    localparam int PKT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 2;
    // Output tdata: byte plus index, padded to whole bytes.
    localparam int M_TDATA_W   = ((BYTE_W + PKT_IDX_W + 7) / 8) * 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SYNC_BYTE   = 2'd0;
    localparam t_cfg_idx CFG_MIN_PAYLOAD = 2'd1;
    localparam t_cfg_idx CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [BYTE_W-1:0]    RST_SYNC_BYTE   = 8'd85;
    localparam logic [PAYLOAD_W-1:0] RST_MIN_PAYLOAD = 4'd2;
    localparam logic [PAYLOAD_W-1:0] RST_MAX_PAYLOAD = 4'd13;

endpackage

`default_nettype wire

// ===== sv/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/servo_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// servo_frame_deframer
// Double-sync, length-prefixed frame deframer for received serial bytes.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer on the slave stream and
// hunts for two header bytes in a row equal to sync_byte. The next byte is
// the packet ID and the one after it the length (command plus data bytes).
// A length within [min_payload, max_payload] and no larger than MAX_BODY
// collects that many body bytes into a small packet RAM; any other length
// drops the header and resumes hunting. Once the frame is complete, the
// packet (ID, length, command, data) is read back from the RAM and sent on
// the master stream, one byte per transfer, with tlast on its final byte.
// No checksum is checked. Rate: while hunting and collecting, one byte is
// taken every cycle. On the byte that completes a frame the input stalls
// while the packet is read out: each packet byte is read from the RAM and
// then loaded into the output register, and the next read is issued only
// once that register is free, so the stall grows with backpressure on the
// master side. The last packet byte may still wait in the output register
// while the next received byte is accepted. The configuration port is
// always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_frame_deframer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire sfd_pkg::t_cfg_idx                  i_cfg_index,
    input  wire logic [sfd_pkg::BYTE_W-1:0]         i_cfg_data,
    // received bytes
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [sfd_pkg::BYTE_W-1:0]         i_s_axis_tdata,   // [7:0] rx_byte
    // packet bytes
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [sfd_pkg::M_TDATA_W-1:0]           o_m_axis_tdata,   // [7:0] pkt_byte,
                                                                      // [11:8] pkt_index,
                                                                      // rest zero
    output logic                                    o_m_axis_tlast    // pkt_last
);

    import sfd_pkg::*;

    typedef enum logic [2:0] {
        HUNT1,
        HUNT2,
        GET_ID,
        GET_LEN,
        BODY,
        EMIT
    } t_phase;

    // configuration
    logic [BYTE_W-1:0]    r_sync_byte;
    logic [PAYLOAD_W-1:0] r_min_payload;
    logic [PAYLOAD_W-1:0] r_max_payload;

    // frame control
    t_phase             r_phase,   n_phase;
    logic [LEN_W-1:0]   r_len,     n_len;
    logic [LEN_W-1:0]   r_left,    n_left;
    logic [ADDR_W-1:0]  r_wr_ptr,  n_wr_ptr;
    logic [ADDR_W-1:0]  r_rd_ptr,  n_rd_ptr;
    logic               r_rd_pend, n_rd_pend;

    // output register
    logic                 r_m_valid, n_m_valid;
    logic [BYTE_W-1:0]    r_m_byte,  n_m_byte;
    logic [PKT_IDX_W-1:0] r_m_index, n_m_index;
    logic                 r_m_last,  n_m_last;

    // packet RAM controls
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    logic              in_xfer;
    logic              out_xfer;
    logic              out_free;
    logic [BYTE_W-1:0] rx_byte;
    logic              len_ok;
    logic              rd_last;

    assign rx_byte  = i_s_axis_tdata;
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_m_valid && i_m_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;

    // Length must sit inside the configured bounds and fit the store.
    assign len_ok = (rx_byte >= {{(BYTE_W-PAYLOAD_W){1'b0}}, r_min_payload}) &&
                    (rx_byte <= {{(BYTE_W-PAYLOAD_W){1'b0}}, r_max_payload}) &&
                    (rx_byte <= BYTE_W'(MAX_BODY));

    // Final packet entry sits at address len + 1.
    assign rd_last = (r_rd_ptr == (ADDR_W'(r_len) + ADDR_W'(1)));

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_left    = r_left;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_rd_pend = r_rd_pend;
        n_m_valid = r_m_valid && !out_xfer;
        n_m_byte  = r_m_byte;
        n_m_index = r_m_index;
        n_m_last  = r_m_last;
        ram_we    = 1'b0;
        ram_waddr = r_wr_ptr;
        ram_re    = 1'b0;

        unique case (r_phase)
            HUNT1: begin
                if (in_xfer && rx_byte == r_sync_byte) begin
                    n_phase = HUNT2;
                end
            end
            HUNT2: begin
                if (in_xfer) begin
                    n_phase = (rx_byte == r_sync_byte) ? GET_ID : HUNT1;
                end
            end
            GET_ID: begin
                if (in_xfer) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(0);
                    n_phase   = GET_LEN;
                end
            end
            GET_LEN: begin
                if (in_xfer) begin
                    if (len_ok) begin
                        // store the length; zero length emits ID and length at once
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(1);
                        n_len     = rx_byte[LEN_W-1:0];
                        n_left    = rx_byte[LEN_W-1:0];
                        n_wr_ptr  = ADDR_W'(2);
                        n_rd_ptr  = '0;
                        n_rd_pend = 1'b0;
                        n_phase   = (rx_byte == '0) ? EMIT : BODY;
                    end else begin
                        n_phase = HUNT1;
                    end
                end
            end
            BODY: begin
                if (in_xfer) begin
                    ram_we   = 1'b1;
                    n_wr_ptr = r_wr_ptr + ADDR_W'(1);
                    n_left   = r_left - LEN_W'(1);
                    if (r_left == LEN_W'(1)) begin
                        n_rd_ptr  = '0;
                        n_rd_pend = 1'b0;
                        n_phase   = EMIT;
                    end
                end
            end
            EMIT: begin
                if (r_rd_pend) begin
                    // read data is here; output register was freed when issued
                    n_m_valid = 1'b1;
                    n_m_byte  = ram_rdata;
                    n_m_index = PKT_IDX_W'(r_rd_ptr);
                    n_m_last  = rd_last;
                    n_rd_pend = 1'b0;
                    if (rd_last) begin
                        n_phase = HUNT1;
                    end else begin
                        n_rd_ptr = r_rd_ptr + ADDR_W'(1);
                    end
                end else if (out_free) begin
                    ram_re    = 1'b1;
                    n_rd_pend = 1'b1;
                end
            end
            default: begin
                n_phase = HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= HUNT1;
            r_left        <= '0;
            r_rd_pend     <= 1'b0;
            r_m_valid     <= 1'b0;
            r_sync_byte   <= RST_SYNC_BYTE;
            r_min_payload <= RST_MIN_PAYLOAD;
            r_max_payload <= RST_MAX_PAYLOAD;
        end else begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_rd_pend <= n_rd_pend;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SYNC_BYTE:   r_sync_byte   <= i_cfg_data;
                    CFG_MIN_PAYLOAD: r_min_payload <= i_cfg_data[PAYLOAD_W-1:0];
                    CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[PAYLOAD_W-1:0];
                    default: begin
                        // unused index: drop the write
                    end
                endcase
            end
        end
        // payload and pointers need no reset
        r_len     <= n_len;
        r_wr_ptr  <= n_wr_ptr;
        r_rd_ptr  <= n_rd_ptr;
        r_m_byte  <= n_m_byte;
        r_m_index <= n_m_index;
        r_m_last  <= n_m_last;
    end

    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_pkt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_phase != EMIT);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-BYTE_W-PKT_IDX_W){1'b0}}, r_m_index, r_m_byte};
    assign o_m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire
